// ----- rtl/core/afn_pkg.sv -----
// Package for the Latin accent fold normalizer: shared types, widths and the
// accent fold table for code points C0..17F. No dependencies.
`timescale 1ns / 1ps
package afn_pkg;

    localparam int CP_W     = 21;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 3;
    localparam int LUT_W    = 9;
    localparam int LUT_IDX_W = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    localparam logic [CP_W-1:0]   FOLD_LO   = 21'h0000C0;
    localparam logic [CP_W-1:0]   FOLD_HI   = 21'h00017F;
    localparam logic [BYTE_W-1:0] CHR_A     = 8'h61;
    localparam logic [BYTE_W-1:0] CHR_E     = 8'h65;
    localparam logic [BYTE_W-1:0] CHR_I     = 8'h69;
    localparam logic [BYTE_W-1:0] CHR_J     = 8'h6A;
    localparam logic [BYTE_W-1:0] CHR_O     = 8'h6F;
    localparam logic [BYTE_W-1:0] CHR_S     = 8'h73;
    localparam logic [CNT_W-1:0]  CNT_ONE   = 3'd1;
    localparam logic [CNT_W-1:0]  CNT_TWO   = 3'd2;
    localparam logic [CNT_W-1:0]  CNT_THREE = 3'd3;
    localparam logic [CNT_W-1:0]  CNT_FOUR  = 3'd4;

    typedef struct packed {
        logic              is_pair;
        logic [BYTE_W-1:0] byte_a;
        logic [BYTE_W-1:0] byte_b;
        logic [CP_W-1:0]   ch;
    } fold_t;

    localparam logic [LUT_W-1:0] FOLD_LUT [192] = '{
        9'h041, 9'h041, 9'h041, 9'h041, 9'h041, 9'h041, 9'h0C6, 9'h043,
        9'h045, 9'h045, 9'h045, 9'h045, 9'h049, 9'h049, 9'h049, 9'h049,
        9'h0D0, 9'h04E, 9'h04F, 9'h04F, 9'h04F, 9'h04F, 9'h04F, 9'h0D7,
        9'h04F, 9'h055, 9'h055, 9'h055, 9'h055, 9'h059, 9'h0DE, 9'h0DF,
        9'h061, 9'h061, 9'h061, 9'h061, 9'h061, 9'h061, 9'h0E6, 9'h063,
        9'h065, 9'h065, 9'h065, 9'h065, 9'h069, 9'h069, 9'h069, 9'h069,
        9'h0F0, 9'h06E, 9'h06F, 9'h06F, 9'h06F, 9'h06F, 9'h06F, 9'h0F7,
        9'h06F, 9'h075, 9'h075, 9'h075, 9'h075, 9'h079, 9'h0FE, 9'h079,
        9'h041, 9'h061, 9'h041, 9'h061, 9'h041, 9'h061, 9'h043, 9'h063,
        9'h043, 9'h063, 9'h043, 9'h063, 9'h043, 9'h063, 9'h044, 9'h064,
        9'h110, 9'h111, 9'h045, 9'h065, 9'h045, 9'h065, 9'h045, 9'h065,
        9'h045, 9'h065, 9'h045, 9'h065, 9'h047, 9'h067, 9'h047, 9'h067,
        9'h047, 9'h067, 9'h047, 9'h067, 9'h048, 9'h068, 9'h126, 9'h127,
        9'h049, 9'h069, 9'h049, 9'h069, 9'h049, 9'h069, 9'h049, 9'h069,
        9'h049, 9'h069, 9'h132, 9'h133, 9'h04A, 9'h06A, 9'h04B, 9'h06B,
        9'h138, 9'h04C, 9'h06C, 9'h04C, 9'h06C, 9'h04C, 9'h06C, 9'h04C,
        9'h06C, 9'h141, 9'h142, 9'h04E, 9'h06E, 9'h04E, 9'h06E, 9'h04E,
        9'h06E, 9'h06E, 9'h14A, 9'h14B, 9'h04F, 9'h06F, 9'h04F, 9'h06F,
        9'h04F, 9'h06F, 9'h152, 9'h153, 9'h052, 9'h072, 9'h052, 9'h072,
        9'h052, 9'h072, 9'h053, 9'h073, 9'h053, 9'h073, 9'h053, 9'h073,
        9'h053, 9'h073, 9'h054, 9'h074, 9'h054, 9'h074, 9'h166, 9'h167,
        9'h055, 9'h075, 9'h055, 9'h075, 9'h055, 9'h075, 9'h055, 9'h075,
        9'h055, 9'h075, 9'h055, 9'h075, 9'h057, 9'h077, 9'h059, 9'h079,
        9'h059, 9'h05A, 9'h07A, 9'h05A, 9'h07A, 9'h05A, 9'h07A, 9'h073
    };

endpackage

// ----- rtl/core/afn_fold.sv -----
// Stage 1: umlaut expansion, sharp s and ligature pairs, accent fold lookup.
// Depends on afn_pkg.
`timescale 1ns / 1ps
module afn_fold (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   german_mode,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [afn_pkg::CP_W-1:0] code_point,
    output logic                   out_valid,
    input  logic                   out_ready,
    output afn_pkg::fold_t         out_data
);
    import afn_pkg::*;

    logic                 valid_reg;
    fold_t                data_reg;
    fold_t                data_next;
    logic [CP_W-1:0]      low;
    logic                 umlaut;
    logic [LUT_W-1:0]     base;
    logic [LUT_W-1:0]     lut_off;
    logic [LUT_W-1:0]     umlaut_off;

    assign low        = code_point | 21'h000020;
    assign umlaut_off = low[LUT_W-1:0] - FOLD_LO[LUT_W-1:0];
    assign lut_off    = code_point[LUT_W-1:0] - FOLD_LO[LUT_W-1:0];
    assign base       = FOLD_LUT[umlaut_off[LUT_IDX_W-1:0]] | 9'h020;

    always_comb begin
        umlaut = german_mode &&
                 (code_point == 21'h0000C4 || code_point == 21'h0000CB ||
                  code_point == 21'h0000CF || code_point == 21'h0000D6 ||
                  code_point == 21'h0000DC || code_point == 21'h0000E4 ||
                  code_point == 21'h0000EB || code_point == 21'h0000EF ||
                  code_point == 21'h0000F6 || code_point == 21'h0000FC);
        data_next.is_pair = 1'b1;
        data_next.byte_a  = '0;
        data_next.byte_b  = '0;
        data_next.ch      = code_point;
        if (umlaut) begin
            data_next.byte_a = base[BYTE_W-1:0];
            data_next.byte_b = CHR_E;
        end else if (code_point == 21'h0000DF) begin
            data_next.byte_a = CHR_S;
            data_next.byte_b = CHR_S;
        end else if (code_point == 21'h0000C6 || code_point == 21'h0000E6) begin
            data_next.byte_a = CHR_A;
            data_next.byte_b = CHR_E;
        end else if (code_point == 21'h000132 || code_point == 21'h000133) begin
            data_next.byte_a = CHR_I;
            data_next.byte_b = CHR_J;
        end else if (code_point == 21'h000152 || code_point == 21'h000153) begin
            data_next.byte_a = CHR_O;
            data_next.byte_b = CHR_E;
        end else begin
            data_next.is_pair = 1'b0;
            if (code_point >= FOLD_LO && code_point <= FOLD_HI) begin
                data_next.ch = {{(CP_W-LUT_W){1'b0}}, FOLD_LUT[lut_off[LUT_IDX_W-1:0]]};
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/core/afn_case.sv -----
// Stage 2: lowercasing of the folded code point.
// Depends on afn_pkg.
`timescale 1ns / 1ps
module afn_case (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  afn_pkg::fold_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output afn_pkg::fold_t out_data
);
    import afn_pkg::*;

    logic  valid_reg;
    fold_t data_reg;
    fold_t data_next;

    always_comb begin
        data_next = in_data;
        if (!in_data.is_pair) begin
            if ((in_data.ch >= 21'h000041 && in_data.ch <= 21'h00005A) ||
                in_data.ch == 21'h0000D0 || in_data.ch == 21'h0000DE) begin
                data_next.ch = in_data.ch | 21'h000020;
            end else if (in_data.ch == 21'h000110 || in_data.ch == 21'h000126 ||
                         in_data.ch == 21'h000141 || in_data.ch == 21'h000166) begin
                data_next.ch = in_data.ch + 21'd1;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/core/afn_enc.sv -----
// Stage 3: UTF-8 encoding into four bytes and a count; output register.
// Depends on afn_pkg.
`timescale 1ns / 1ps
module afn_enc (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  afn_pkg::fold_t               in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [afn_pkg::M_DATA_W-1:0] out_data
);
    import afn_pkg::*;

    logic                valid_reg;
    logic [M_DATA_W-1:0] data_reg;
    logic [M_DATA_W-1:0] data_next;
    logic [BYTE_W-1:0]   b0, b1, b2, b3;
    logic [CNT_W-1:0]    cnt;
    logic [CP_W-1:0]     c;

    assign c = in_data.ch;

    always_comb begin
        b1  = '0;
        b2  = '0;
        b3  = '0;
        if (in_data.is_pair) begin
            b0  = in_data.byte_a;
            b1  = in_data.byte_b;
            cnt = CNT_TWO;
        end else if (c < 21'h000080) begin
            b0  = {1'b0, c[6:0]};
            cnt = CNT_ONE;
        end else if (c < 21'h000800) begin
            b0  = {3'b110, c[10:6]};
            b1  = {2'b10, c[5:0]};
            cnt = CNT_TWO;
        end else if (c < 21'h010000) begin
            b0  = {4'b1110, c[15:12]};
            b1  = {2'b10, c[11:6]};
            b2  = {2'b10, c[5:0]};
            cnt = CNT_THREE;
        end else begin
            b0  = {5'b11110, c[20:18]};
            b1  = {2'b10, c[17:12]};
            b2  = {2'b10, c[11:6]};
            b3  = {2'b10, c[5:0]};
            cnt = CNT_FOUR;
        end
        data_next = {5'b0, cnt, b3, b2, b1, b0};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/core/latin_accent_fold_normalizer.sv -----
// Latin accent fold normalizer: code point in, normalized UTF-8 bytes out.
// Depends on afn_pkg, afn_fold, afn_case, afn_enc.
//
// Usage:
//   Input words on s_tvalid/s_tready/s_tdata carry one code point each.
//   Output words on m_tvalid/m_tready/m_tdata carry one to four UTF-8 bytes
//   and a byte count; unused bytes are zero. One output word per input word,
//   in order.
//   cfg_wr_en/cfg_wr_data write german_mode; write it only while the block is
//   empty. It reads 0 after reset.
//   Words pass through the fold, lowercase and encode stages, each registered,
//   to m_tvalid. Throughput is one word per cycle while m_tready is high.
//   Each stage holds its word while the next one is full; ready ripples back
//   per stage, so bubbles are squeezed out and a stalled receiver only stops
//   input once all three stages are full. Nothing is dropped or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline and clears
//   german_mode.
`timescale 1ns / 1ps
module latin_accent_fold_normalizer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [afn_pkg::S_DATA_W-1:0] s_tdata,  // [20:0] code_point
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [afn_pkg::M_DATA_W-1:0] m_tdata   // out_byte0..3, byte_count
);
    import afn_pkg::*;

    logic  german_mode_reg;
    logic  fold_valid, fold_ready;
    fold_t fold_data;
    logic  case_valid, case_ready;
    fold_t case_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            german_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            german_mode_reg <= cfg_wr_data;
        end
    end

    afn_fold u_fold (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .german_mode (german_mode_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .code_point  (s_tdata[CP_W-1:0]),
        .out_valid   (fold_valid),
        .out_ready   (fold_ready),
        .out_data    (fold_data)
    );

    afn_case u_case (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fold_valid),
        .in_ready  (fold_ready),
        .in_data   (fold_data),
        .out_valid (case_valid),
        .out_ready (case_ready),
        .out_data  (case_data)
    );

    afn_enc u_enc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (case_valid),
        .in_ready  (case_ready),
        .in_data   (case_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ----- rtl/core/afn_checker.sv -----
// Port-level checks for the normalizer output word, bound to the top level.
// Depends on afn_pkg and latin_accent_fold_normalizer.
`timescale 1ns / 1ps
module afn_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [afn_pkg::M_DATA_W-1:0] m_tdata
);
    import afn_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled word changed");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34:32] == CNT_ONE || m_tdata[34:32] == CNT_TWO ||
                      m_tdata[34:32] == CNT_THREE || m_tdata[34:32] == CNT_FOUR))
        else $error("byte count out of range");

    a_one_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34:32] == CNT_ONE |-> m_tdata[31:8] == 24'h0 && !m_tdata[7])
        else $error("single byte word malformed");

    a_two_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34:32] == CNT_TWO |-> m_tdata[31:16] == 16'h0)
        else $error("unused bytes not zero");

endmodule

bind latin_accent_fold_normalizer afn_checker u_afn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
